>>> hdl/pt64_pkg.sv
// ----------------------------------------------------------------------------
// pt64_pkg
// Shared types and constants for the 64-bit primality tester.
// ----------------------------------------------------------------------------
package pt64_pkg;

    localparam int BASE_COUNT = 7;
    localparam int BASE_WIDTH = 31;
    localparam int BASE_IDX_WIDTH = 3;

    // Fixed witness bases of the deterministic test.
    localparam logic [BASE_WIDTH-1:0] WITNESS_BASES [BASE_COUNT] = '{
        31'd2, 31'd325, 31'd9375, 31'd28178, 31'd450775, 31'd9780504,
        31'd1795265022
    };

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SPLIT,
        ST_BASE,
        ST_DIV,
        ST_POW_STEP,
        ST_POW_MUL,
        ST_POW_SQR,
        ST_TEST,
        ST_SQR,
        ST_SQR_TEST,
        ST_DONE
    } state_t;

endpackage

>>> hdl/pt64_mulmod.sv
// ----------------------------------------------------------------------------
// pt64_mulmod
// Bit-serial modular multiplier: one multiplier bit per cycle, shift and add.
// ----------------------------------------------------------------------------
module pt64_mulmod #(
    parameter int W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] x,
    input  logic [W-1:0] y,
    input  logic [W-1:0] m,
    output logic         done,
    output logic [W-1:0] result
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] y_reg, y_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [W-1:0] dbl;
    logic [W-1:0] room;

    // Doubling then conditional add, both modulo m.
    always_comb
    begin
        room = m - acc_reg;
        dbl = (acc_reg >= room) ? acc_reg - room : acc_reg + acc_reg;
        acc_next = acc_reg;
        y_next = y_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next = '0;
            y_next = y;
            cnt_next = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (y_reg[W-1])
            begin
                acc_next = (dbl >= m - x) ? dbl - (m - x) : dbl + x;
            end
            else
            begin
                acc_next = dbl;
            end
            y_next = y_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        y_reg <= y_next;
    end

    assign done = done_reg;
    assign result = acc_reg;
endmodule

>>> hdl/pt64_remdiv.sv
// ----------------------------------------------------------------------------
// pt64_remdiv
// Bit-serial remainder of n by a small base, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module pt64_remdiv #(
    parameter int W = 64,
    parameter int BW = 31
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [W-1:0]  n,
    input  logic [BW-1:0] d,
    output logic          done,
    output logic          is_zero
);
    localparam int CW = $clog2(W + 1);

    logic [BW:0] rem_reg, rem_next;
    logic [W-1:0] n_reg, n_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;
    logic [BW+1:0] sh;

    // Restoring division step on the remainder only.
    always_comb
    begin
        sh = {rem_reg, n_reg[W-1]};
        rem_next = rem_reg;
        n_next = n_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            n_next = n;
            cnt_next = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (sh >= {2'b00, d})
            begin
                rem_next = (BW+1)'(sh - {2'b00, d});
            end
            else
            begin
                rem_next = (BW+1)'(sh);
            end
            n_next = n_reg << 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        n_reg <= n_next;
    end

    assign done = done_reg;
    assign is_zero = (rem_reg == '0);
endmodule

>>> hdl/primality_test_64.sv
// ----------------------------------------------------------------------------
// primality_test_64
// Deterministic Miller-Rabin test with seven fixed bases on a bit-serial
// modular multiplier.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    candidate [63:0]
// out      output     out_valid / out_stall  prime_flag
//
// One candidate is worked at a time. Each modular multiply runs on the shared
// shift-and-add multiplier; n-1 is split into odd part and power of two at one
// bit per cycle. Each base needs a remainder pass and up to about 2*NUM_WIDTH
// multiplies. Reset clears the sequencer to idle.
// The result is held in an output register while out_stall is high; the next
// input transfer is taken once that register has been emptied.
// ----------------------------------------------------------------------------
module primality_test_64 #(
    parameter int NUM_WIDTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] candidate,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        prime_flag
);
    import pt64_pkg::*;

    localparam int W = NUM_WIDTH;
    localparam int SW = $clog2(W + 1);

    state_t state_reg, state_next;
    logic [W-1:0] n_reg, n_next;
    logic [W-1:0] base_reg, base_next;
    logic [W-1:0] x_reg, x_next;
    logic [W-1:0] e_reg, e_next;
    logic [W-1:0] d_reg, d_next;
    logic [SW-1:0] s_reg, s_next;
    logic [SW-1:0] r_reg, r_next;
    logic [BASE_IDX_WIDTH-1:0] idx_reg, idx_next;
    logic ov_reg, ov_next;
    logic flag_reg, flag_next;

    logic mm_start;
    logic [W-1:0] mm_x, mm_y;
    logic mm_done;
    logic [W-1:0] mm_res;
    logic dv_start, dv_done, dv_zero;
    logic [W-1:0] nm1;
    logic [W-1:0] cur_base;
    logic accept;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE) || ov_reg;
    assign nm1 = n_reg - 1'b1;
    assign cur_base = W'({33'd0, WITNESS_BASES[idx_reg]});

    pt64_mulmod #(.W(W)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(mm_start), .x(mm_x), .y(mm_y),
        .m(n_reg), .done(mm_done), .result(mm_res)
    );

    pt64_remdiv #(.W(W), .BW(BASE_WIDTH)) u_div (
        .clk(clk), .rst_n(rst_n), .start(dv_start), .n(n_reg),
        .d(WITNESS_BASES[idx_reg]), .done(dv_done), .is_zero(dv_zero)
    );

    // Sequencer for the base loop, exponentiation and squaring rounds.
    always_comb
    begin
        state_next = state_reg;
        n_next = n_reg;
        base_next = base_reg;
        x_next = x_reg;
        e_next = e_reg;
        d_next = d_reg;
        s_next = s_reg;
        r_next = r_reg;
        idx_next = idx_reg;
        ov_next = ov_reg;
        flag_next = flag_reg;
        mm_start = 1'b0;
        mm_x = x_reg;
        mm_y = base_reg;
        dv_start = 1'b0;
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    n_next = candidate[W-1:0];
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                d_next = nm1;
                s_next = '0;
                idx_next = '0;
                if (n_reg < W'(2))
                begin
                    flag_next = 1'b0;
                    state_next = ST_DONE;
                end
                else if (n_reg == W'(2) || n_reg == W'(3))
                begin
                    flag_next = 1'b1;
                    state_next = ST_DONE;
                end
                else if (!n_reg[0])
                begin
                    flag_next = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SPLIT;
                end
            end
            // Strip one trailing zero of n-1 per cycle.
            ST_SPLIT:
            begin
                if (d_reg[0])
                begin
                    state_next = ST_BASE;
                end
                else
                begin
                    d_next = d_reg >> 1;
                    s_next = s_reg + 1'b1;
                end
            end
            ST_BASE:
            begin
                if (32'(idx_reg) >= BASE_COUNT ||
                    {33'd0, WITNESS_BASES[idx_reg]} >= 64'(n_reg))
                begin
                    flag_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    dv_start = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (dv_done)
                begin
                    if (dv_zero)
                    begin
                        flag_next = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        base_next = cur_base;
                        x_next = W'(1);
                        e_next = d_reg;
                        state_next = ST_POW_STEP;
                    end
                end
            end
            ST_POW_STEP:
            begin
                if (e_reg == '0)
                begin
                    state_next = ST_TEST;
                end
                else if (e_reg[0])
                begin
                    mm_start = 1'b1;
                    mm_x = x_reg;
                    mm_y = base_reg;
                    state_next = ST_POW_MUL;
                end
                else
                begin
                    mm_start = 1'b1;
                    mm_x = base_reg;
                    mm_y = base_reg;
                    state_next = ST_POW_SQR;
                end
            end
            ST_POW_MUL:
            begin
                if (mm_done)
                begin
                    x_next = mm_res;
                    mm_start = 1'b1;
                    mm_x = base_reg;
                    mm_y = base_reg;
                    state_next = ST_POW_SQR;
                end
            end
            ST_POW_SQR:
            begin
                mm_x = base_reg;
                mm_y = base_reg;
                if (mm_done)
                begin
                    base_next = mm_res;
                    e_next = e_reg >> 1;
                    state_next = ST_POW_STEP;
                end
            end
            ST_TEST:
            begin
                r_next = SW'(1);
                if (x_reg == W'(1) || x_reg == nm1)
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = ST_BASE;
                end
                else
                begin
                    state_next = ST_SQR_TEST;
                end
            end
            ST_SQR_TEST:
            begin
                if (r_reg >= s_reg)
                begin
                    flag_next = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    mm_start = 1'b1;
                    mm_x = x_reg;
                    mm_y = x_reg;
                    state_next = ST_SQR;
                end
            end
            ST_SQR:
            begin
                mm_x = x_reg;
                mm_y = x_reg;
                if (mm_done)
                begin
                    x_next = mm_res;
                    r_next = r_reg + 1'b1;
                    if (mm_res == nm1)
                    begin
                        idx_next = idx_reg + 1'b1;
                        state_next = ST_BASE;
                    end
                    else
                    begin
                        state_next = ST_SQR_TEST;
                    end
                end
            end
            ST_DONE:
            begin
                if (!ov_reg)
                begin
                    ov_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg <= 1'b0;
            idx_reg <= '0;
            r_reg <= '0;
            s_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
            idx_reg <= idx_next;
            r_reg <= r_next;
            s_reg <= s_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        base_reg <= base_next;
        x_reg <= x_next;
        e_reg <= e_next;
        d_reg <= d_next;
        flag_reg <= flag_next;
    end

    assign out_valid = ov_reg;
    assign prime_flag = flag_reg;

    // A held result must not change while stalled.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(prime_flag))
        else $error("result changed while stalled");

    // No input transfer while a result is pending.
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");

    // No multiply is started while the sequencer is idle.
    a_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mm_start)
        else $error("multiply started while idle");
endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Primality tester testbench
// Sends 64-bit candidates through the valid/stall input channel, predicts
// each primality flag with a local deterministic Miller-Rabin computation,
// and checks every output transfer in order under random idling and stalls.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NUM_WIDTH = 64;
    localparam int RANDOM_ITEMS = 130;

    // Witness bases of the deterministic test.
    localparam logic [63:0] BASES [7] = '{
        64'd2, 64'd325, 64'd9375, 64'd28178, 64'd450775, 64'd9780504,
        64'd1795265022
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] candidate;
    logic        out_valid;
    logic        out_stall;
    logic        prime_flag;

    logic [63:0] pending_candidates [$];
    logic        expected_flags [$];
    int          mismatch_count;
    bit          stimulus_done;
    int          send_gap;
    int          stall_left;

    primality_test_64 #(.NUM_WIDTH(NUM_WIDTH)) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .candidate  (candidate),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .prime_flag (prime_flag)
    );

    // Clock with a period of four time units.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // (x + y) mod m for x, y below m.
    function automatic logic [63:0] add_mod(logic [63:0] x, logic [63:0] y,
                                            logic [63:0] m);
        logic [63:0] room;
        room = m - y;
        return (x >= room) ? x - room : x + y;
    endfunction

    // (x * y) mod m by shift-and-add from the top bit of y.
    function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y,
                                            logic [63:0] m);
        logic [63:0] acc;
        acc = '0;
        for (int b = 63; b >= 0; b--)
        begin
            acc = add_mod(acc, acc, m);
            if (y[b])
                acc = add_mod(acc, x, m);
        end
        return acc;
    endfunction

    function automatic logic [63:0] pow_mod(logic [63:0] a, logic [63:0] e,
                                            logic [63:0] m);
        logic [63:0] acc;
        acc = 64'd1;
        while (e != 0)
        begin
            if (e[0])
                acc = mul_mod(acc, a, m);
            a = mul_mod(a, a, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    // Strong probable-prime test of odd n above three against base a.
    function automatic bit strong_pass(logic [63:0] n, logic [63:0] a);
        logic [63:0] d;
        logic [63:0] x;
        int          s;
        if (n % a == 0)
            return 1'b0;
        d = n - 1;
        s = 0;
        while (!d[0])
        begin
            d = d >> 1;
            s++;
        end
        x = pow_mod(a, d, n);
        if (x == 1 || x == n - 1)
            return 1'b1;
        for (int r = 1; r < s; r++)
        begin
            x = mul_mod(x, x, n);
            if (x == n - 1)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit predict_prime(logic [63:0] n);
        if (n < 2)
            return 1'b0;
        if (n == 2 || n == 3)
            return 1'b1;
        if (!n[0])
            return 1'b0;
        for (int i = 0; i < 7; i++)
        begin
            if (BASES[i] >= n)
                break;
            if (!strong_pass(n, BASES[i]))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Mostly short gaps, occasionally a long one, sometimes none.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Stimulus: directed corner cases, then random candidates.
    initial
    begin
        logic [63:0] v;
        logic [63:0] directed [$];
        directed = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd9, 64'd65,
                     64'd325, 64'd341, 64'd3215031751, 64'd1795265022,
                     64'd1795265023, 64'd4294967291, 64'd4294967297,
                     64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFFF,
                     64'hFFFF_FFFF_FFFF_FFFE, 64'h8000_0000_0000_0001,
                     64'd3825123056546413051, 64'd18446744073709551557,
                     64'hAAAA_AAAA_AAAA_AAAB, 64'h5555_5555_5555_5555};
        foreach (directed[i])
            pending_candidates = {pending_candidates, directed[i]};
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            case ($urandom_range(0, 3))
                0: v = rand64() | 64'd1;
                1: v = {32'd0, $urandom} | 64'd1;
                2: v = {48'd0, 16'($urandom)};
                default: v = rand64();
            endcase
            pending_candidates = {pending_candidates, v};
        end
    end

    // Reset and input defaults.
    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        candidate = '0;
        out_stall = 1'b0;
        mismatch_count = 0;
        stimulus_done = 1'b0;
        send_gap = 0;
        stall_left = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver: one candidate per transfer, with random gaps between them.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_flags = {expected_flags, predict_prime(candidate)};
                void'(pending_candidates.pop_front());
                send_gap = pick_gap();
                if (pending_candidates.size() == 0)
                    stimulus_done <= 1'b1;
            end
            if (!(in_valid && in_stall))
            begin
                if (send_gap > 0 || pending_candidates.size() == 0)
                begin
                    if (send_gap > 0)
                        send_gap--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    candidate <= pending_candidates[0];
                end
            end
        end
    end

    // Monitor: compare each output transfer against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_flags.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected transfer: prime_flag=%0b", prime_flag);
                end
                else if (prime_flag !== expected_flags[0])
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("prime_flag mismatch: expected %0b, got %0b",
                                 expected_flags[0], prime_flag);
                    void'(expected_flags.pop_front());
                end
                else
                    void'(expected_flags.pop_front());
            end
            // Receiver stalls in random bursts.
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = pick_gap();
                out_stall <= (stall_left > 0);
            end
        end
    end

    // End of run once every prediction has been checked.
    initial
    begin
        wait (stimulus_done);
        while (expected_flags.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #200000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
hdl/pt64_pkg.sv
hdl/pt64_mulmod.sv
hdl/pt64_remdiv.sv
hdl/primality_test_64.sv
tb/sv/testbench.sv
